/* rtl/dtrm_pkg.sv */
package dtrm_pkg;

   localparam int AVERAGE_DEPTH = 4;
   localparam int TIMEOUT_US    = 1000000;
   localparam int US_PER_SECOND = 1000000;
   localparam int FACTOR_LIMIT  = 4294;

   localparam int FILTER_W  = 8;
   localparam int FACTOR_W  = 13;
   localparam int TIME_W    = 32;
   localparam int RPM_W     = 32;
   localparam int CSR_W     = 13;
   localparam int US_W      = 20;
   localparam int WIN_IW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int SUM_W     = RPM_W + $clog2(AVERAGE_DEPTH);
   localparam int REM_W     = RPM_W + 1;

   localparam logic CSR_FILTER_LENGTH     = 1'b0;
   localparam logic CSR_CONVERSION_FACTOR = 1'b1;

   typedef struct packed {
      logic load;
      logic clear;
      logic mul;
      logic div_start;
      logic win_write;
      logic sum_clear;
      logic sum_acc;
      logic rpm_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fall;
      logic period_zero;
      logic timeout;
      logic div_done;
      logic sum_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/dtrm_divider.sv */
module dtrm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dtrm_pkg::RPM_W-1:0]    dividend,
   input  logic [dtrm_pkg::RPM_W-1:0]    divisor,
   output logic                          done,
   output logic [dtrm_pkg::RPM_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(dtrm_pkg::RPM_W + 1);

   logic [dtrm_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [dtrm_pkg::RPM_W-1:0] quo_ff, quo_in;
   logic [dtrm_pkg::RPM_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [dtrm_pkg::REM_W-1:0] shifted;
   logic [dtrm_pkg::REM_W-1:0] den_ext;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[dtrm_pkg::RPM_W-1:0], quo_ff[dtrm_pkg::RPM_W-1]};
      den_ext = {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(dtrm_pkg::RPM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (shifted >= den_ext) begin
            rem_in = shifted - den_ext;
            quo_in = {quo_ff[dtrm_pkg::RPM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[dtrm_pkg::RPM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/dtrm_datapath.sv */
module dtrm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dtrm_pkg::cmd_type               cmd,
   output dtrm_pkg::status_type            status,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [dtrm_pkg::CSR_W-1:0]      csr_write_data,
   input  logic                            req_pin_level,
   input  logic [dtrm_pkg::TIME_W-1:0]     req_now_us,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dtrm_pkg::RPM_W-1:0]      rsp_rpm,
   output logic                            rsp_debounced_level,
   output logic                            rsp_new_measurement
);

   localparam int DEPTH = dtrm_pkg::AVERAGE_DEPTH;

   logic [dtrm_pkg::FILTER_W-1:0] filter_length_ff;
   logic [dtrm_pkg::FACTOR_W-1:0] factor_ff;

   logic [dtrm_pkg::FILTER_W-1:0] count_ff, count_step, count_in;
   logic                          level_ff, level_in;
   logic [dtrm_pkg::TIME_W-1:0]   last_edge_ff;
   logic [dtrm_pkg::TIME_W-1:0]   elapsed;
   logic [dtrm_pkg::TIME_W-1:0]   period_ff;
   logic                          fall_ff, fall_in;
   logic                          timeout_ff;
   logic [dtrm_pkg::RPM_W-1:0]    rpm_ff;

   logic [dtrm_pkg::RPM_W-1:0]    window_ff [DEPTH];
   logic [dtrm_pkg::WIN_IW-1:0]   pos_ff;
   logic [dtrm_pkg::WIN_IW-1:0]   sum_idx_ff;
   logic [dtrm_pkg::SUM_W-1:0]    sum_ff;
   logic [dtrm_pkg::SUM_W-1:0]    window_mean;

   logic [dtrm_pkg::FACTOR_W-1:0] factor_clamped;
   logic [dtrm_pkg::US_W-1:0]     us_const;
   logic [dtrm_pkg::RPM_W-1:0]    product_ff;

   logic                          div_done;
   logic [dtrm_pkg::RPM_W-1:0]    div_quotient;

   logic                          rsp_valid_ff;
   logic [dtrm_pkg::RPM_W-1:0]    rsp_rpm_ff;
   logic                          rsp_level_ff;
   logic                          rsp_meas_ff;

   // integrator; the high clamp wins over the zero test, so a zero length forces high
   always_comb begin
      if (req_pin_level) begin
         count_step = (count_ff < filter_length_ff) ?
                      count_ff + dtrm_pkg::FILTER_W'(1) : count_ff;
      end else begin
         count_step = (count_ff != '0) ? count_ff - dtrm_pkg::FILTER_W'(1) : count_ff;
      end
      count_in = count_step;
      level_in = level_ff;
      if (count_step == '0) begin
         level_in = 1'b0;
      end
      if (count_step >= filter_length_ff) begin
         level_in = 1'b1;
         count_in = filter_length_ff;
      end
      fall_in = level_ff & ~level_in;
   end

   assign elapsed = req_now_us - last_edge_ff;

   assign factor_clamped = (factor_ff > dtrm_pkg::FACTOR_W'(dtrm_pkg::FACTOR_LIMIT)) ?
                           dtrm_pkg::FACTOR_W'(dtrm_pkg::FACTOR_LIMIT) : factor_ff;
   assign us_const = dtrm_pkg::US_W'(dtrm_pkg::US_PER_SECOND);

   // window depth is a power of two, so this is a shift
   assign window_mean = sum_ff / dtrm_pkg::SUM_W'(DEPTH);

   dtrm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_length_ff <= dtrm_pkg::FILTER_W'(8);
         factor_ff        <= dtrm_pkg::FACTOR_W'(60);
      end else if (csr_write_enable) begin
         case (csr_index)
            dtrm_pkg::CSR_FILTER_LENGTH:
               filter_length_ff <= csr_write_data[dtrm_pkg::FILTER_W-1:0];
            dtrm_pkg::CSR_CONVERSION_FACTOR:
               factor_ff <= csr_write_data[dtrm_pkg::FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         period_ff  <= elapsed;
         fall_ff    <= fall_in;
         timeout_ff <= ~fall_in && (rpm_ff != '0) &&
                       (elapsed >= dtrm_pkg::TIME_W'(dtrm_pkg::TIMEOUT_US));
      end
      if (cmd.mul) begin
         product_ff <= dtrm_pkg::RPM_W'(us_const) * dtrm_pkg::RPM_W'(factor_clamped);
      end
      if (cmd.sum_clear) begin
         sum_ff     <= '0;
         sum_idx_ff <= '0;
      end else if (cmd.sum_acc) begin
         sum_ff     <= sum_ff + dtrm_pkg::SUM_W'(window_ff[sum_idx_ff]);
         sum_idx_ff <= (sum_idx_ff == dtrm_pkg::WIN_IW'(DEPTH - 1)) ?
                       '0 : sum_idx_ff + dtrm_pkg::WIN_IW'(1);
      end
      if (cmd.out_load) begin
         rsp_rpm_ff   <= rpm_ff;
         rsp_level_ff <= level_ff;
         rsp_meas_ff  <= fall_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         level_ff     <= 1'b0;
         last_edge_ff <= '0;
         rpm_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            count_ff <= count_in;
            level_ff <= level_in;
            if (fall_in) begin
               last_edge_ff <= req_now_us;
            end
         end
         if (cmd.clear) begin
            rpm_ff <= '0;
            pos_ff <= '0;
            for (int i = 0; i < DEPTH; i++) begin
               window_ff[i] <= '0;
            end
         end else if (cmd.win_write) begin
            window_ff[pos_ff] <= div_quotient;
            pos_ff <= (pos_ff == dtrm_pkg::WIN_IW'(DEPTH - 1)) ?
                      '0 : pos_ff + dtrm_pkg::WIN_IW'(1);
         end
         if (cmd.rpm_load) begin
            rpm_ff <= window_mean[dtrm_pkg::RPM_W-1:0];
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.fall        = fall_ff;
      status.period_zero = (period_ff == '0);
      status.timeout     = timeout_ff;
      status.div_done    = div_done;
      status.sum_last    = (sum_idx_ff == dtrm_pkg::WIN_IW'(DEPTH - 1));
      status.out_free    = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rpm             = rsp_rpm_ff;
   assign rsp_debounced_level = rsp_level_ff;
   assign rsp_new_measurement = rsp_meas_ff;

endmodule

/* rtl/dtrm_controller.sv */
module dtrm_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dtrm_pkg::status_type  status,
   output dtrm_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_RPM,
      ST_WAIT_RPM,
      ST_SUM,
      ST_MEAN,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.fall && !status.period_zero) begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV_RPM;
            end else begin
               // zero period or timeout: speed zero, window emptied; any other sample keeps both
               cmd.clear = (status.fall && status.period_zero) || status.timeout;
               state_in  = ST_OUT;
            end
         end
         ST_DIV_RPM: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_RPM;
         end
         ST_WAIT_RPM: begin
            if (status.div_done) begin
               cmd.win_write = 1'b1;
               cmd.sum_clear = 1'b1;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_acc = 1'b1;
            if (status.sum_last) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.rpm_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/debounced_tach_rpm_meter.sv */
// Debounced tachometer speed meter. Each accepted word is one pin sample with its
// microsecond timestamp and yields exactly one result word: averaged rpm, debounced
// level and a flag for a fresh period measurement. A sample without a falling edge of
// the debounced level passes the decide and output states to the output register, and
// the next word can be taken after that. A falling edge with a nonzero period also
// passes multiply, divide, window write, sum and mean: a radix-2 divider computes
// 1000000*factor/period one quotient bit per cycle, the window is summed one entry per
// cycle, and the mean is a shift. The next word is taken once the result is in the
// output register, even while that register is still stalled; a result waiting behind
// a stalled one holds the input off. Configuration writes (filter length, conversion
// factor) take effect on the next word if made while idle; the block does not enforce it.
module debounced_tach_rpm_meter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_pin_level,
   input  logic [dtrm_pkg::TIME_W-1:0]   req_now_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dtrm_pkg::RPM_W-1:0]    rsp_rpm,
   output logic                          rsp_debounced_level,
   output logic                          rsp_new_measurement,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [dtrm_pkg::CSR_W-1:0]    csr_write_data
);

   dtrm_pkg::cmd_type    cmd;
   dtrm_pkg::status_type status;

   dtrm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dtrm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_pin_level       (req_pin_level),
      .req_now_us          (req_now_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rpm             (rsp_rpm),
      .rsp_debounced_level (rsp_debounced_level),
      .rsp_new_measurement (rsp_new_measurement)
   );

endmodule
